[sv/bhte_pkg.sv]
// shared types and constants for the button hold timeout event block
`default_nettype none

package bhte_pkg;

  // controller count by default and fixed sizes
  localparam int BHTE_CONTROLLERS = 4;
  localparam int NUM_BUTTONS      = 12;
  localparam int MAX_EVENTS       = 48;
  localparam int TIMEOUT_W        = 20;
  localparam int TIMER_W          = 21;
  localparam int ELAPSED_W        = 16;
  localparam int COUNT_W          = $clog2(MAX_EVENTS + 1);

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd150000;

  // one button event as it travels to the output stage
  typedef struct packed {
    logic [1:0] player;
    logic [3:0] button;
    logic       pressed;
  } event_t;

  // one entry of the per-controller state memory
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] pending;
    logic                   changed;
    logic [NUM_BUTTONS-1:0] current;
    logic [NUM_BUTTONS-1:0] previous;
    logic [TIMER_W-1:0]     timer;
  } entry_t;

endpackage

`default_nettype wire

[sv/bhte_evt_out.sv]
// output stage: one-event holding slot ahead of the registered stream output
`default_nettype none

module bhte_evt_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bhte_pkg::event_t push_ev,
  input  wire logic            flush,
  output logic                 ready,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // event_player[1:0], event_button[5:2], zero
  output logic                 m_axis_tuser,  // event_pressed
  output logic                 m_axis_tlast   // event_last
);
  import bhte_pkg::*;

  logic   hold_valid;
  event_t hold_ev;
  logic   out_valid;
  event_t out_ev;
  logic   out_last;

  // the held event moves on once the output register is free or draining
  assign ready = !hold_valid || !out_valid || m_axis_tready;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (push && ready) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
        end
        hold_valid <= 1'b1;
      end else if (flush && ready && hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  // payload: a held event is known to be last only when the tick ends
  always_ff @(posedge clk) begin
    if (push && ready) begin
      if (hold_valid) begin
        out_ev   <= hold_ev;
        out_last <= 1'b0;
      end
      hold_ev <= push_ev;
    end else if (flush && ready && hold_valid) begin
      out_ev   <= hold_ev;
      out_last <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_ev.button, out_ev.player};
  assign m_axis_tuser  = out_ev.pressed;
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

[sv/button_hold_timeout_edge_events.sv]
// top level: controller state memory, report and tick sequencer
`default_nettype none

// Button hold qualifier for CONTROLLERS game controllers of 12 buttons each.
// A report transaction (tuser 0) stores the decoded buttons as the pending
// mask of a controller; a tick transaction (tuser 1) walks all controllers and
// emits press then release events, tlast on the final event of the tick, none
// on a quiet tick. The per-controller entries live in one single-port memory
// that is read, modified and written back once per controller. A report
// passes a read and a write state before the next ready; one for a controller
// that does not exist is ignored. A tick reads and evaluates each controller,
// emits its events, and ends in a closing flush state; a stalled output
// stretches this. At most 48 events leave per tick. After reset every
// controller reads as all zero.
module button_hold_timeout_edge_events #(
  parameter int CONTROLLERS = bhte_pkg::BHTE_CONTROLLERS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [bhte_pkg::TIMEOUT_W-1:0] cfg_wr_data,  // hold_timeout_us
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // player[7:0], buttons_low[15:8], buttons_high[23:16], elapsed_us[39:24]
  input  wire logic [39:0]                  s_axis_tdata,
  input  wire logic                         s_axis_tuser,  // action
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // event_player[1:0], event_button[5:2]
  output logic                              m_axis_tuser,  // event_pressed
  output logic                              m_axis_tlast   // event_last
);
  import bhte_pkg::*;

  localparam int CW = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
  localparam int EW = 2 * NUM_BUTTONS;
  localparam int IW = $clog2(EW);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RPT_RD  = 3'd1;
  localparam logic [2:0] ST_RPT_WR  = 3'd2;
  localparam logic [2:0] ST_TK_RD   = 3'd3;
  localparam logic [2:0] ST_TK_EVAL = 3'd4;
  localparam logic [2:0] ST_TK_EMIT = 3'd5;
  localparam logic [2:0] ST_FLUSH   = 3'd6;

  localparam logic ACT_REPORT = 1'b0;

  // report bytes to button mask
  function automatic logic [NUM_BUTTONS-1:0] decode_buttons(input logic [7:0] lo,
                                                            input logic [7:0] hi);
    logic [NUM_BUTTONS-1:0] m;
    m = '0;
    for (int i = 0; i < 6; i++) begin
      m[i]     = lo[5-i];
      m[6 + i] = hi[7-i];
    end
    return m;
  endfunction

  logic [2:0]             state;
  logic [CW-1:0]          ctrl;
  logic [ELAPSED_W-1:0]   elapsed;
  logic [NUM_BUTTONS-1:0] rpt_mask;
  logic [EW-1:0]          emit_mask;
  logic [COUNT_W-1:0]     ev_count;
  logic [TIMEOUT_W-1:0]   hold_timeout_us;
  logic [CONTROLLERS-1:0] entry_valid;

  entry_t                 mem [CONTROLLERS];
  entry_t                 rd_data;
  entry_t                 ent;
  entry_t                 wr_data;
  logic                   mem_we;

  logic                   in_fire;
  logic                   ctrl_last;
  logic [NUM_BUTTONS-1:0] prev_m;
  logic [NUM_BUTTONS-1:0] cur_m;
  logic                   do_emit;
  logic [TIMER_W:0]       timer_sum;
  logic [EW-1:0]          low_bit;
  logic [IW-1:0]          low_idx;
  logic                   push;
  logic                   push_ready;
  event_t                 push_ev;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ctrl_last     = (ctrl == CW'(CONTROLLERS - 1));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout_us <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      hold_timeout_us <= cfg_wr_data;
    end
  end

  // state memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ctrl] <= wr_data;
    end
    rd_data <= mem[ctrl];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[ctrl] <= 1'b1;
    end
  end

  assign ent = entry_valid[ctrl] ? rd_data : '0;

  // per-controller update on a report write or a tick
  always_comb begin
    timer_sum = {1'b0, ent.timer} + (TIMER_W + 1)'(elapsed);
    prev_m    = ent.previous;
    cur_m     = ent.pending;
    do_emit   = 1'b1;
    wr_data   = ent;
    if (state == ST_RPT_WR) begin
      wr_data.pending = rpt_mask;
      wr_data.changed = 1'b1;
    end else if (ent.changed) begin
      wr_data.changed  = 1'b0;
      wr_data.timer    = '0;
      wr_data.current  = ent.pending;
      wr_data.previous = ent.pending;
    end else if (ent.timer < TIMER_W'(hold_timeout_us)) begin
      do_emit       = 1'b0;
      wr_data.timer = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];
    end else begin
      // hold timed out: release everything
      prev_m           = ent.current;
      cur_m            = '0;
      wr_data.pending  = '0;
      wr_data.current  = '0;
      wr_data.previous = '0;
      wr_data.timer    = '0;
    end
  end

  assign mem_we = (state == ST_RPT_WR) || (state == ST_TK_EVAL);

  // lowest pending event: presses in the low half, releases in the high half
  assign low_bit = emit_mask & (~emit_mask + EW'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < EW; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | IW'(i);
      end
    end
  end

  always_comb begin
    push_ev.player  = 2'(ctrl);
    push_ev.pressed = (low_idx < IW'(NUM_BUTTONS));
    push_ev.button  = push_ev.pressed ? 4'(low_idx) : 4'(low_idx - IW'(NUM_BUTTONS));
  end

  assign push = (state == ST_TK_EMIT) && (emit_mask != '0) &&
                (ev_count < COUNT_W'(MAX_EVENTS));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == ACT_REPORT) begin
              if (s_axis_tdata[7:0] < 8'(CONTROLLERS)) begin
                state <= ST_RPT_RD;
              end
            end else begin
              state <= ST_TK_RD;
            end
          end
        end
        ST_RPT_RD:  state <= ST_RPT_WR;
        ST_RPT_WR:  state <= ST_IDLE;
        ST_TK_RD:   state <= ST_TK_EVAL;
        ST_TK_EVAL: begin
          if (do_emit && ((prev_m ^ cur_m) != '0)) begin
            state <= ST_TK_EMIT;
          end else if (ctrl_last) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_TK_RD;
          end
        end
        ST_TK_EMIT: begin
          if (emit_mask == '0) begin
            state <= ctrl_last ? ST_FLUSH : ST_TK_RD;
          end
        end
        ST_FLUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sequencer datapath; a tick walks the controllers from the first one
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl     <= (s_axis_tuser == ACT_REPORT) ? CW'(s_axis_tdata[7:0]) : '0;
          rpt_mask <= decode_buttons(s_axis_tdata[15:8], s_axis_tdata[23:16]);
          elapsed  <= s_axis_tdata[39:24];
          ev_count <= '0;
        end
      end
      ST_TK_EVAL: begin
        emit_mask <= {prev_m & ~cur_m, cur_m & ~prev_m};
        if (!(do_emit && ((prev_m ^ cur_m) != '0)) && !ctrl_last) begin
          ctrl <= ctrl + CW'(1);
        end
      end
      ST_TK_EMIT: begin
        if (emit_mask == '0) begin
          if (!ctrl_last) begin
            ctrl <= ctrl + CW'(1);
          end
        end else if (!push) begin
          // over the per-tick limit: drop
          emit_mask <= emit_mask & ~low_bit;
        end else if (push_ready) begin
          emit_mask <= emit_mask & ~low_bit;
          ev_count  <= ev_count + COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  bhte_evt_out u_evt_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_ev       (push_ev),
    .flush         (state == ST_FLUSH),
    .ready         (push_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[sv/bhte_checker.sv]
// port-level checks for the button hold timeout event block, bound to the top
`default_nettype none

module bhte_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled event holds its content
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled event changed");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("event right after reset");

  // button index in range and padding bits zero
  a_button_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:2] < 4'd12) && (m_axis_tdata[7:6] == 2'b00))
    else $error("bad event payload");

  // a tick keeps the input closed while controllers are walked
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input open during tick");

endmodule

bind button_hold_timeout_edge_events bhte_checker u_bhte_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
